// ----- rtl/ntoa_pkg.sv -----
// Package for the number to ASCII formatter.
// Holds the transfer payload types, opcode codes, character constants and the hex digit function.
// Has no dependencies.
package ntoa_pkg;

  localparam logic [2:0] OP_RAW  = 3'd0;
  localparam logic [2:0] OP_PHEX = 3'd1;
  localparam logic [2:0] OP_WHEX = 3'd2;
  localparam logic [2:0] OP_BHEX = 3'd3;
  localparam logic [2:0] OP_DEC  = 3'd4;
  localparam logic [2:0] OP_CRLF = 3'd5;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] HEX_ALPHA   = 8'd55;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return {4'd0, nib} + HEX_ALPHA;
    end
    return {4'd0, nib} + CHAR_ZERO;
  endfunction

endpackage

// ----- rtl/ntoa_dabble.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on nothing outside this file.
module ntoa_dabble (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] value_i,
  output logic        busy_o,
  output logic [19:0] bcd_o
);

  logic [15:0] bin_q, bin_d;
  logic [19:0] bcd_q, bcd_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [19:0] adj;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (start_i) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = 5'd16;
    end else if (cnt_q != 5'd0) begin
      bin_d = {bin_q[14:0], 1'b0};
      bcd_d = {adj[18:0], bin_q[15]};
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign bcd_o  = bcd_q;

endmodule

// ----- rtl/number_to_ascii_formatter.sv -----
// Top level of the number to ASCII formatter.
// Depends on ntoa_pkg and ntoa_dabble.
//
// One item is taken at a time and its characters leave one per cycle through an output
// register, while the output is not stalled. Raw byte, hex and CRLF items give 1 to 6
// characters after acceptance. Decimal items are accepted, converted by the bit-serial BCD
// converter and its result loaded, then leading zeros are skipped one at a time before the
// skip step is left, and then the digits are emitted. Skipped zeros and digits always add up
// to five.
// The next item is accepted in the cycle after the last character enters the output
// register. Opcodes 6 and 7 are accepted and produce no characters.
module number_to_ascii_formatter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ntoa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ntoa_pkg::out_item_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SKIP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [2:0]  op_q, op_d;
  logic [19:0] sh_q, sh_d;
  logic [2:0]  left_q, left_d;
  logic [1:0]  pre_q, pre_d;
  logic        out_valid_q, out_valid_d;
  ntoa_pkg::out_item_t out_q, out_d;

  logic        accept;
  logic        load;
  logic        conv_start;
  logic        conv_busy;
  logic [19:0] conv_bcd;
  logic [7:0]  ch;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign conv_start = accept && (in_data_i.opcode == ntoa_pkg::OP_DEC);
  assign load       = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  ntoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (in_data_i.value),
    .busy_o  (conv_busy),
    .bcd_o   (conv_bcd)
  );

  always_comb begin
    case (op_q)
      ntoa_pkg::OP_RAW:  ch = sh_q[19:12];
      ntoa_pkg::OP_CRLF: ch = (pre_q == 2'd2) ? ntoa_pkg::CHAR_CR : ntoa_pkg::CHAR_LF;
      ntoa_pkg::OP_PHEX: begin
        if (pre_q == 2'd2) begin
          ch = ntoa_pkg::CHAR_ZERO;
        end else if (pre_q == 2'd1) begin
          ch = ntoa_pkg::CHAR_X;
        end else begin
          ch = ntoa_pkg::hex_char(sh_q[19:16]);
        end
      end
      ntoa_pkg::OP_DEC:  ch = {4'd0, sh_q[19:16]} + ntoa_pkg::CHAR_ZERO;
      default:           ch = ntoa_pkg::hex_char(sh_q[19:16]);
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sh_d    = sh_q;
    left_d  = left_q;
    pre_d   = pre_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = in_data_i.opcode;
          pre_d   = 2'd0;
          sh_d    = {in_data_i.value[7:0], 12'd0};
          state_d = S_EMIT;
          case (in_data_i.opcode)
            ntoa_pkg::OP_RAW:  left_d = 3'd1;
            ntoa_pkg::OP_PHEX: begin
              pre_d = 2'd2;
              if (in_data_i.value[15:8] == 8'd0) begin
                left_d = 3'd4;
              end else begin
                sh_d   = {in_data_i.value, 4'd0};
                left_d = 3'd6;
              end
            end
            ntoa_pkg::OP_WHEX: begin
              sh_d   = {in_data_i.value, 4'd0};
              left_d = 3'd4;
            end
            ntoa_pkg::OP_BHEX: left_d = 3'd2;
            ntoa_pkg::OP_DEC: begin
              left_d  = 3'd5;
              state_d = S_CONV;
            end
            ntoa_pkg::OP_CRLF: begin
              pre_d  = 2'd2;
              left_d = 3'd2;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CONV: begin
        if (!conv_busy) begin
          sh_d    = conv_bcd;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        if ((sh_q[19:16] == 4'd0) && (left_q > 3'd1)) begin
          sh_d   = {sh_q[15:0], 4'd0};
          left_d = left_q - 3'd1;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          left_d = left_q - 3'd1;
          if (pre_q != 2'd0) begin
            pre_d = pre_q - 2'd1;
          end else begin
            sh_d = {sh_q[15:0], 4'd0};
          end
          if (left_q == 3'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_valid_d     = 1'b1;
      out_d.character = ch;
      out_d.last      = (left_q == 3'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    sh_q   <= sh_d;
    left_q <= left_d;
    pre_q  <= pre_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/ntoa_checker.sv -----
// Port-level assertions for the number to ASCII formatter, bound to the top level.
// Depends on ntoa_pkg and number_to_ascii_formatter.
module ntoa_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ntoa_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ntoa_pkg::out_item_t out_data_o
);

  // A stalled output transfer keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output payload changed while stalled");

  // A formatting opcode ends input readiness until its characters are produced.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode <= ntoa_pkg::OP_CRLF) |=> !in_ready_o)
    else $error("input ready right after a formatting item");

  // Unused opcodes produce nothing and leave the input ready.
  a_unused_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode > ntoa_pkg::OP_CRLF) && !out_valid_o
    |=> in_ready_o && !out_valid_o)
    else $error("unused opcode produced output");

  // More characters are pending whenever a non-final character is shown.
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready while an item is unfinished");

endmodule

bind number_to_ascii_formatter ntoa_checker u_ntoa_checker (.*);

// ----- verif/ntoa_text_checker.sv -----
// Checker for the number to ASCII formatter: watches both transfer channels,
// predicts the characters of every accepted item and compares them in order.
// Depends on ntoa_pkg.
module ntoa_text_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ntoa_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ntoa_pkg::out_item_t out_data_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  ntoa_pkg::out_item_t expected_text[$];
  ntoa_pkg::out_item_t head;

  function automatic logic [7:0] digit_ascii(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ntoa_pkg::CHAR_ZERO + 8'(nib);
    end
    return CHAR_UPPER_A + 8'(nib - 4'd10);
  endfunction

  function automatic void queue_text(input ntoa_pkg::in_item_t item);
    logic [7:0]          text[$];
    logic [15:0]         rest;
    int                  nhex;
    ntoa_pkg::out_item_t entry;
    nhex = 0;
    rest = item.value;
    case (item.opcode)
      ntoa_pkg::OP_RAW: begin
        text.push_back(item.value[7:0]);
      end
      ntoa_pkg::OP_PHEX: begin
        text.push_back(ntoa_pkg::CHAR_ZERO);
        text.push_back(ntoa_pkg::CHAR_X);
        nhex = (item.value <= 16'h00FF) ? 2 : 4;
      end
      ntoa_pkg::OP_WHEX: begin
        nhex = 4;
      end
      ntoa_pkg::OP_BHEX: begin
        nhex = 2;
      end
      ntoa_pkg::OP_DEC: begin
        if (rest == 16'd0) begin
          text.push_back(ntoa_pkg::CHAR_ZERO);
        end
        while (rest != 16'd0) begin
          text.push_front(ntoa_pkg::CHAR_ZERO + 8'(rest % 16'd10));
          rest = rest / 16'd10;
        end
      end
      ntoa_pkg::OP_CRLF: begin
        text.push_back(ntoa_pkg::CHAR_CR);
        text.push_back(ntoa_pkg::CHAR_LF);
      end
      default: begin
      end
    endcase
    for (int i = nhex - 1; i >= 0; i--) begin
      text.push_back(digit_ascii(item.value[4*i +: 4]));
    end
    for (int k = 0; k < text.size(); k++) begin
      entry.character = text[k];
      entry.last      = (k == text.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $display("%0t: expected none, got character %h last %b", $time,
                   out_data_i.character, out_data_i.last);
          mismatch_count_o++;
        end else begin
          head = expected_text.pop_front();
          if (out_data_i.character !== head.character) begin
            $display("%0t: character expected %h, got %h", $time,
                     head.character, out_data_i.character);
            mismatch_count_o++;
          end
          if (out_data_i.last !== head.last) begin
            $display("%0t: last expected %b, got %b", $time,
                     head.last, out_data_i.last);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        queue_text(in_data_i);
      end
      pending_o = expected_text.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the number to ASCII formatter: drives directed and random
// items, random stalls on both channels, and gives the verdict.
// Depends on ntoa_pkg, number_to_ascii_formatter and ntoa_text_checker.
module tb_top;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int         ITEM_GOAL = 130;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  ntoa_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ntoa_pkg::out_item_t out_data_o;
  int                  mismatch_count;
  int                  pending_chars;
  int                  sent_count;
  int                  send_idle_pct;
  bit                  held_off;

  ntoa_pkg::in_item_t directed_items[] = '{
    {ntoa_pkg::OP_RAW,  16'h0000}, {ntoa_pkg::OP_RAW,  16'h00FF},
    {ntoa_pkg::OP_RAW,  16'hAB12}, {ntoa_pkg::OP_PHEX, 16'h0000},
    {ntoa_pkg::OP_PHEX, 16'h00FF}, {ntoa_pkg::OP_PHEX, 16'h0100},
    {ntoa_pkg::OP_PHEX, 16'hFFFF}, {ntoa_pkg::OP_WHEX, 16'h0000},
    {ntoa_pkg::OP_WHEX, 16'hFFFF}, {ntoa_pkg::OP_WHEX, 16'h1A2F},
    {ntoa_pkg::OP_BHEX, 16'h0000}, {ntoa_pkg::OP_BHEX, 16'hFFA5},
    {ntoa_pkg::OP_DEC,  16'd0},    {ntoa_pkg::OP_DEC,  16'd9},
    {ntoa_pkg::OP_DEC,  16'd10},   {ntoa_pkg::OP_DEC,  16'd9999},
    {ntoa_pkg::OP_DEC,  16'd10000}, {ntoa_pkg::OP_DEC, 16'd65535},
    {ntoa_pkg::OP_CRLF, 16'h0000}, {ntoa_pkg::OP_CRLF, 16'hFFFF},
    {OP_SPARE6, 16'h1234},         {OP_SPARE7, 16'hFFFF}
  };

  number_to_ascii_formatter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  ntoa_text_checker u_text_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_chars)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_item(input ntoa_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sent_count >= 30 && !held_off) begin
        // Long receiver stall while the sender keeps offering items.
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else if (sent_count >= 60 && sent_count < 95) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    ntoa_pkg::in_item_t item;
    int                 pick;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    rst_ni        = 1'b0;
    sent_count    = 0;
    send_idle_pct = 37;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_items[k]) begin
      offer_item(directed_items[k]);
    end
    while (sent_count < ITEM_GOAL) begin
      send_idle_pct = (sent_count >= 70 && sent_count < 100) ? 0 : 37;
      if ($urandom_range(99) < 8) begin
        item.opcode = 3'($urandom_range(OP_SPARE6, OP_SPARE7));
      end else begin
        item.opcode = 3'($urandom_range(ntoa_pkg::OP_RAW, ntoa_pkg::OP_CRLF));
      end
      pick = $urandom_range(3);
      case (pick)
        0: item.value = 16'($urandom_range(16'hFFFF));
        1: item.value = 16'($urandom_range(255));
        2: begin
          case ($urandom_range(7))
            0: item.value = 16'd0;
            1: item.value = 16'd255;
            2: item.value = 16'd256;
            3: item.value = 16'd99;
            4: item.value = 16'd100;
            5: item.value = 16'd999;
            6: item.value = 16'd1000;
            default: item.value = 16'hFFFF;
          endcase
        end
        default: item.value = 16'($urandom_range(9, 1024));
      endcase
      offer_item(item);
    end
    in_valid_i <= 1'b0;
    while (pending_chars != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && pending_chars == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ntoa_pkg.sv
rtl/ntoa_dabble.sv
rtl/number_to_ascii_formatter.sv
rtl/ntoa_checker.sv
verif/ntoa_text_checker.sv
verif/tb_top.sv
